// ----- hdl/psc_pkg.sv -----
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types, codes and constants of the postfix stack calculator.
// ----------------------------------------------------------------------------
package psc_pkg;

  localparam int DefaultStackDepth = 1024;
  localparam int WordWidth   = 32;
  localparam int ActionWidth = 3;
  localparam int IndexWidth  = 10;
  localparam int StatusWidth = 3;
  localparam int DepthWidth  = 11;

  typedef enum logic [ActionWidth-1:0] {
    ACT_PUSH        = 3'd0,
    ACT_POP         = 3'd1,
    ACT_ADD         = 3'd2,
    ACT_SUB         = 3'd3,
    ACT_MUL         = 3'd4,
    ACT_DIV         = 3'd5,
    ACT_PEEK_TOP    = 3'd6,
    ACT_PEEK_BOTTOM = 3'd7
  } action_t;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_FEW     = 3'd3,
    ST_DIVZERO = 3'd4,
    ST_RANGE   = 3'd5
  } status_t;

  // Decoded command handed from the front end to the execution unit.
  typedef struct packed {
    action_t                action;
    logic [WordWidth-1:0]   push_value;
    logic [IndexWidth-1:0]  peek_index;
    logic                   is_arith;
    logic                   is_peek;
  } cmd_t;

endpackage

// ----- hdl/psc_cmd_if.sv -----
// ----------------------------------------------------------------------------
// psc_cmd_if
// Valid/ready channels: command requests in, result requests out.
// ----------------------------------------------------------------------------
interface psc_cmd_if import psc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [ActionWidth-1:0] action;
  logic [WordWidth-1:0]   push_value;
  logic [IndexWidth-1:0]  peek_index;
  modport source (output valid, action, push_value, peek_index, input ready);
  modport sink   (input valid, action, push_value, peek_index, output ready);
endinterface

interface psc_res_if import psc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [WordWidth-1:0]   result_value;
  logic [StatusWidth-1:0] status;
  logic [DepthWidth-1:0]  depth;
  modport source (output valid, result_value, status, depth, input ready);
  modport sink   (input valid, result_value, status, depth, output ready);
endinterface

// ----- hdl/psc_ram.sv -----
// ----------------------------------------------------------------------------
// psc_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module psc_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- hdl/psc_front.sv -----
// ----------------------------------------------------------------------------
// psc_front
// Accepts command requests, classifies them, and queues them (two entries).
// ----------------------------------------------------------------------------
module psc_front import psc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  psc_cmd_if.sink       cmd,
  output logic          q_valid,
  output cmd_t          q_cmd,
  input  logic          q_pop
);
  cmd_t       slot [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] fill;
  cmd_t       incoming;
  logic       push_en;

  assign cmd.ready = (fill != 2'd2);
  assign push_en   = cmd.valid && cmd.ready;

  // Classify the request
  always_comb begin
    incoming.action     = action_t'(cmd.action);
    incoming.push_value = cmd.push_value;
    incoming.peek_index = cmd.peek_index;
    incoming.is_arith   = (cmd.action == ACT_ADD) || (cmd.action == ACT_SUB) ||
                          (cmd.action == ACT_MUL) || (cmd.action == ACT_DIV);
    incoming.is_peek    = (cmd.action == ACT_PEEK_TOP) ||
                          (cmd.action == ACT_PEEK_BOTTOM);
  end

  assign q_valid = (fill != 2'd0);
  assign q_cmd   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_en) begin
      slot[wr_ptr] <= incoming;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push_en) wr_ptr <= ~wr_ptr;
      if (q_pop)   rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push_en} - {1'b0, q_pop};
    end
  end
endmodule

// ----- hdl/psc_div.sv -----
// ----------------------------------------------------------------------------
// psc_div
// Iterative signed floor divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psc_div import psc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [WordWidth-1:0] dividend,
  input  logic [WordWidth-1:0] divisor,
  output logic                 done,
  output logic [WordWidth-1:0] quotient
);
  localparam int CntWidth = $clog2(WordWidth + 1);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} dstate_t;

  dstate_t              state;
  logic [WordWidth-1:0] rem, quo, dvs;
  logic                 neg_q;
  logic [CntWidth-1:0]  cnt;
  logic [WordWidth:0]   trial;
  logic [WordWidth-1:0] rem_shift;

  assign rem_shift = {rem[WordWidth-2:0], quo[WordWidth-1]};
  assign trial     = {rem, quo[WordWidth-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (start) begin
            rem   <= '0;
            quo   <= dividend[WordWidth-1] ? -dividend : dividend;
            dvs   <= divisor[WordWidth-1] ? -divisor : divisor;
            neg_q <= dividend[WordWidth-1] ^ divisor[WordWidth-1];
            cnt   <= CntWidth'(WordWidth);
            state <= D_RUN;
          end
        end
        D_RUN: begin
          // Restoring step on magnitudes
          if (!trial[WordWidth]) begin
            rem <= trial[WordWidth-1:0];
            quo <= {quo[WordWidth-2:0], 1'b1};
          end else begin
            rem <= rem_shift;
            quo <= {quo[WordWidth-2:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
          if (cnt == CntWidth'(1)) state <= D_FIX;
        end
        D_FIX: begin
          // Sign and floor adjust: inexact negative quotient steps down
          if (neg_q) begin
            quotient <= (rem != '0) ? ~quo : -quo;
          end else begin
            quotient <= quo;
          end
          done  <= 1'b1;
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end
endmodule

// ----- hdl/psc_exec.sv -----
// ----------------------------------------------------------------------------
// psc_exec
// Back end: carries out one command against the stack RAM and registers the
// result request.
// ----------------------------------------------------------------------------
module psc_exec import psc_pkg::*; #(
  parameter int StackDepth = DefaultStackDepth
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  psc_res_if.source  res
);
  localparam int AddrWidth = $clog2(StackDepth);
  localparam int CntWidth  = $clog2(StackDepth + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_RD_T, S_RD_S, S_OPS, S_MUL, S_DIV, S_PEEK, S_OUT
  } state_t;

  state_t                state;
  logic [CntWidth-1:0]   count;
  cmd_t                  cur;
  logic [WordWidth-1:0]  top_word, sec_word, value;
  logic [StatusWidth-1:0] status;
  logic [63:0]           prod;
  logic                  ram_we;
  logic [AddrWidth-1:0]  ram_addr;
  logic [WordWidth-1:0]  ram_wdata, ram_rdata;
  logic                  div_start, div_done;
  logic [WordWidth-1:0]  div_q;
  logic [CntWidth-1:0]   idx_ext;

  psc_ram #(.Width(WordWidth), .Depth(StackDepth)) u_ram (
    .clk, .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  psc_div u_div (
    .clk, .rst, .start(div_start), .dividend(sec_word), .divisor(top_word),
    .done(div_done), .quotient(div_q)
  );

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign div_start = (state == S_MUL) && (cur.action == ACT_DIV)
                     && (top_word != '0);
  assign idx_ext   = CntWidth'(cur.peek_index);

  // RAM address / write select
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = '0;
    ram_wdata = value;
    case (state)
      S_IDLE: begin
        ram_we    = q_valid && (q_cmd.action == ACT_PUSH)
                    && (count != CntWidth'(StackDepth));
        ram_addr  = count[AddrWidth-1:0];
        ram_wdata = q_cmd.push_value;
      end
      S_RD_T: begin
        if (!cur.is_peek) ram_addr = AddrWidth'(count - 1'b1);
        else if (cur.action == ACT_PEEK_TOP)
          ram_addr = AddrWidth'(count - 1'b1 - idx_ext);
        else ram_addr = AddrWidth'(idx_ext);
      end
      S_RD_S:  ram_addr = AddrWidth'(count - 2'd2);
      S_OUT: begin
        ram_we   = (status == ST_OK) && cur.is_arith;
        ram_addr = AddrWidth'(count - 1'b1);
      end
      default: ram_addr = '0;
    endcase
  end

  assign prod = top_word * sec_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res.valid <= 1'b0;
    end else begin
      if (res.valid && res.ready && state != S_OUT) res.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur    <= q_cmd;
            value  <= '0;
            status <= ST_OK;
            state  <= S_OUT;
            case (q_cmd.action)
              ACT_PUSH: begin
                if (count == CntWidth'(StackDepth)) status <= ST_FULL;
                else count <= count + 1'b1;
              end
              ACT_POP: begin
                if (count == '0) status <= ST_EMPTY;
                else state <= S_RD_T;
              end
              default: begin
                if (q_cmd.is_arith) begin
                  if (count < CntWidth'(2)) status <= ST_FEW;
                  else state <= S_RD_T;
                end else begin
                  if (CntWidth'(q_cmd.peek_index) >= count ||
                      (CntWidth <= IndexWidth &&
                       (q_cmd.peek_index >> CntWidth) != '0)) status <= ST_RANGE;
                  else state <= S_RD_T;
                end
              end
            endcase
          end
        end
        S_RD_T: state <= (cur.action == ACT_POP || cur.is_peek) ? S_PEEK : S_RD_S;
        S_RD_S: begin
          top_word <= ram_rdata;
          state    <= S_OPS;
        end
        S_OPS: begin
          sec_word <= ram_rdata;
          state    <= S_MUL;
        end
        S_MUL: begin
          // Operands now held
          case (cur.action)
            ACT_ADD: value <= sec_word + top_word;
            ACT_SUB: value <= sec_word - top_word;
            ACT_MUL: value <= prod[WordWidth-1:0];
            default: value <= '0;
          endcase
          if (cur.action == ACT_DIV) begin
            if (top_word == '0) begin
              status <= ST_DIVZERO;
              state  <= S_OUT;
            end else begin
              state <= S_DIV;
            end
          end else begin
            count <= count - 1'b1;
            state <= S_OUT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            value <= div_q;
            count <= count - 1'b1;
            state <= S_OUT;
          end
        end
        S_PEEK: begin
          // Read data for a pop or a peek
          value <= ram_rdata;
          if (cur.action == ACT_POP) count <= count - 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!res.valid || res.ready) begin
            res.valid        <= 1'b1;
            res.result_value <= value;
            res.status       <= status;
            res.depth        <= DepthWidth'(count);
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- hdl/postfix_stack_calculator_top.sv -----
// ----------------------------------------------------------------------------
// postfix_stack_calculator_top
// Stack calculator over signed 32-bit words with queued command front end.
// ----------------------------------------------------------------------------
// Usage:
//   cmd: valid/ready channel carrying action, push_value, peek_index.
//   res: valid/ready channel carrying result_value, status, depth.
//   One result request per command request, in order.
// Execution:
//   push and most error commands go straight to the output stage; pop and
//   peek read one RAM word; add/sub/mul and divide by zero read two; divide
//   also waits on the divider, one quotient bit per cycle. One command
//   executes at a time; a two-entry queue keeps accepting requests meanwhile.
// Reset: clears the depth to zero and empties the queue and output stage;
//   stack RAM contents are not cleared and need no clearing pass.
// Stall: a held result request stops the execution unit; the queue fills
//   and then drops cmd.ready.
// ----------------------------------------------------------------------------
module postfix_stack_calculator_top import psc_pkg::*; #(
  parameter int StackDepth = DefaultStackDepth
) (
  input logic       clk,
  input logic       rst,
  psc_cmd_if.sink   cmd,
  psc_res_if.source res
);
  logic q_valid, q_pop;
  cmd_t q_cmd;

  psc_front u_front (.clk, .rst, .cmd, .q_valid, .q_cmd, .q_pop);

  psc_exec #(.StackDepth(StackDepth)) u_exec (
    .clk, .rst, .q_valid, .q_cmd, .q_pop, .res
  );

  // Depth never exceeds capacity
  a_depth: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.depth <= DepthWidth'(StackDepth))
    else $error("depth beyond capacity");

  // Errors return zero
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status != ST_OK) |-> res.result_value == '0)
    else $error("error result not zero");

  // Queue only drained when it holds something
  a_pop: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue underflow");
endmodule
